// ===== src/sfd_pkg.sv =====
// Shared constants and types for the serial frame deframer.
package sfd_pkg;

	localparam logic [7:0]  SYNC_BYTE         = 8'hAA;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1996;

	// Frame phase codes
	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_CSUM   = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	// Register index on the config port
	localparam logic REG_MAX_PAYLOAD = 1'b0;

	// One result from the deframer core
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       frame_end;
		logic       frame_good;
	} sfd_result_t;

endpackage

// ===== src/sfd_core.sv =====
// Deframer state machine: phase, running checksum and byte count.
module sfd_core
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_payload,
	output sfd_result_t result
);

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  sum_acc_q, sum_acc_d;
	logic [7:0]  length_lo_q, length_lo_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [7:0]  sum_next;
	logic [15:0] len;

	assign sum_next = sum_acc_q + rx_byte;
	assign len      = {rx_byte, length_lo_q};

	always_comb begin
		phase_d      = phase_q;
		sum_acc_d    = sum_acc_q;
		length_lo_d  = length_lo_q;
		bytes_left_d = bytes_left_q;
		result       = '0;
		case (phase_q)
			PH_CSUM: begin
				sum_acc_d = sum_next;
				phase_d   = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				sum_acc_d   = sum_next;
				length_lo_d = rx_byte;
				phase_d     = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_acc_d = sum_next;
				if (len > max_payload) begin
					phase_d = PH_HUNT;
				end else if (len == '0) begin
					// empty frame: a lone end marker
					phase_d           = PH_HUNT;
					result.valid      = 1'b1;
					result.frame_end  = 1'b1;
					result.frame_good = (sum_next == '0);
				end else begin
					bytes_left_d = len;
					phase_d      = PH_DATA;
				end
			end
			PH_DATA: begin
				sum_acc_d         = sum_next;
				bytes_left_d      = bytes_left_q - 16'd1;
				result.valid      = 1'b1;
				result.data_byte  = rx_byte;
				result.byte_valid = 1'b1;
				if (bytes_left_q == 16'd1) begin
					phase_d           = PH_HUNT;
					result.frame_end  = 1'b1;
					result.frame_good = (sum_next == '0);
				end
			end
			default: begin
				// hunt; unused codes fall back here too
				phase_d = PH_HUNT;
				if (rx_byte == SYNC_BYTE) begin
					sum_acc_d = SYNC_BYTE;
					phase_d   = PH_CSUM;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			sum_acc_q    <= '0;
			length_lo_q  <= '0;
			bytes_left_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			sum_acc_q    <= sum_acc_d;
			length_lo_q  <= length_lo_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

// ===== src/serial_frame_deframer_unit.sv =====
// Serial frame deframer: top level with config port, input and result registers.
//
// Takes received serial bytes on the slave stream, one per transfer, hunts for
// the sync byte 0xAA, then reads a checksum byte and a little-endian 16-bit
// payload length. Frames longer than max_payload (APB register at address 0,
// reset 1996) are dropped silently. Payload bytes come out on the master
// stream as they arrive; the transfer that closes a frame has tlast set and
// tuser[1] carrying the verdict (8-bit sum of all frame bytes, sync included,
// equals zero). An empty frame closes with a single transfer with no data
// byte (tuser[0] low, tdata zero). Header bytes and bytes outside a frame
// produce no output. Throughput is one byte per clock: each byte is registered
// in the input register, the phase/checksum update runs from there into the
// result register, and the result is offered on the master stream from that
// register. Both registers advance whenever the result register is empty or
// being drained, so the block only stalls when m_tready is held low.
module serial_frame_deframer_unit
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: received bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// master stream: deframed results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic        m_tlast,   // frame_end
	output logic [1:0]  m_tuser,   // [0] byte_valid, [1] frame_good
	// APB config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---------------- config register ----------------
	logic [15:0] max_payload_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_PAYLOAD) begin
			max_payload_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, max_payload_q} : 32'd0;

	// ---------------- input register ----------------
	logic        in_valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        out_free;
	logic        step;

	// result register can take a new value this cycle
	assign out_free = !m_tvalid || m_tready;
	// byte in s1 gets processed (may or may not produce a result)
	assign step     = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// ---------------- deframer core ----------------
	sfd_result_t result;

	sfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (rx_byte_s1),
		.max_payload (max_payload_q),
		.result      (result)
	);

	// ---------------- result register ----------------
	logic        m_valid_q;
	sfd_result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_s2.data_byte;
	assign m_tlast  = res_s2.frame_end;
	assign m_tuser  = {res_s2.frame_good, res_s2.byte_valid};

	// ---------------- assertions ----------------
	// a good verdict only ever rides on the closing transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[1] || m_tlast))
		else $error("frame_good set without frame_end");

	// a result without data is the close of an empty frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
		else $error("dataless result is not an empty-frame close");

	// a byte waiting in s1 is held while the result side is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !step) |=> (in_valid_s1 && $stable(rx_byte_s1)))
		else $error("input register lost a byte while stalled");

	// the core only steps when the result register can take its output
	assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (!m_tvalid || m_tready))
		else $error("core advanced into a full result register");

endmodule

// ===== tb/tb_serial_frame_deframer_unit.sv =====
// Self-checking testbench for the serial frame deframer top level.
`timescale 1ns / 100ps

module tb_serial_frame_deframer_unit;
	import sfd_pkg::*;

	// Tracks the deframer state as bytes are accepted and holds the results
	// that the master stream still owes, oldest first.
	class deframe_scoreboard;
		typedef struct {
			logic [7:0] data_byte;
			logic       byte_valid;
			logic       frame_end;
			logic       frame_good;
		} frame_out_t;

		logic [2:0]  phase;
		logic [7:0]  sum_acc;
		logic [7:0]  len_lo;
		logic [15:0] bytes_left;
		logic [15:0] max_payload;
		frame_out_t  expected_q[$];
		int          mismatches;

		function void restart();
			phase       = PH_HUNT;
			sum_acc     = 8'h00;
			len_lo      = 8'h00;
			bytes_left  = 16'h0000;
			max_payload = MAX_PAYLOAD_RESET;
			expected_q.delete();
			mismatches  = 0;
		endfunction

		function void set_limit(logic [15:0] value);
			max_payload = value;
		endfunction

		function void flag_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// One accepted rx byte: advance the frame state, queue any result.
		function void take_rx_byte(logic [7:0] b);
			logic [15:0] len;
			frame_out_t  r;
			bit          emit;
			emit = 1'b0;
			case (phase)
				PH_CSUM: begin
					sum_acc = sum_acc + b;
					phase   = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					sum_acc = sum_acc + b;
					len_lo  = b;
					phase   = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					sum_acc = sum_acc + b;
					len     = {b, len_lo};
					if (len > max_payload) begin
						// oversized: drop, hunt again from the next byte
						phase = PH_HUNT;
					end else if (len == 16'h0000) begin
						phase = PH_HUNT;
						r     = '{8'h00, 1'b0, 1'b1, sum_acc == 8'h00};
						emit  = 1'b1;
					end else begin
						bytes_left = len;
						phase      = PH_DATA;
					end
				end
				PH_DATA: begin
					sum_acc    = sum_acc + b;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'h0000) begin
						phase = PH_HUNT;
						r     = '{b, 1'b1, 1'b1, sum_acc == 8'h00};
					end else begin
						r = '{b, 1'b1, 1'b0, 1'b0};
					end
					emit = 1'b1;
				end
				default: begin
					// hunting; unused codes behave the same
					phase = PH_HUNT;
					if (b == SYNC_BYTE) begin
						sum_acc = SYNC_BYTE;
						phase   = PH_CSUM;
					end
				end
			endcase
			if (emit)
				expected_q.push_back(r);
		endfunction

		function void check_output(logic [7:0] tdata, logic tlast, logic [1:0] tuser);
			frame_out_t e;
			if (expected_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: tdata %02h tlast %0b tuser %02b",
					tdata, tlast, tuser));
				return;
			end
			e = expected_q.pop_front();
			if (tdata !== e.data_byte || tuser[0] !== e.byte_valid ||
			    tlast !== e.frame_end || tuser[1] !== e.frame_good)
				flag_mismatch($sformatf({"result mismatch: expected data %02h valid %0b ",
					"end %0b good %0b, got data %02h valid %0b end %0b good %0b"},
					e.data_byte, e.byte_valid, e.frame_end, e.frame_good,
					tdata, tuser[0], tlast, tuser[1]));
		endfunction

		function void check_register(logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val)
				flag_mismatch($sformatf("register readback mismatch: expected %08h, got %08h",
					exp_val, act_val));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	deframe_scoreboard sb = new;

	logic [7:0] tx_bytes[$];   // bytes waiting to go out on the slave stream
	bit         steady;        // no idling on either side while set
	bit         long_hold_req; // asks the result sink for one long hold-off

	localparam logic [2:0] MAX_PAYLOAD_ADDR = {REG_MAX_PAYLOAD, 2'b00};

	serial_frame_deframer_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Build one frame into tx_bytes. The checksum byte is solved so the byte
	// sum comes out zero, then spoiled when a bad frame is wanted. The last
	// 'cut' bytes are left off, for truncated frames and for oversized ones
	// where only the header matters.
	task automatic queue_frame(int len, bit good, int cut);
		logic [7:0]  frame[$];
		logic [7:0]  sum;
		logic [7:0]  b;
		logic [15:0] l16;
		l16 = len[15:0];
		frame.push_back(SYNC_BYTE);
		frame.push_back(8'h00);
		frame.push_back(l16[7:0]);
		frame.push_back(l16[15:8]);
		sum = SYNC_BYTE + l16[7:0] + l16[15:8];
		for (int i = 0; i < len - cut; i++) begin
			b = $urandom_range(0, 255);
			frame.push_back(b);
			sum = sum + b;
		end
		frame[1] = -sum;
		if (!good)
			frame[1] = frame[1] + 8'($urandom_range(1, 255));
		for (int i = 0; i < frame.size() && i < len + 4 - cut; i++)
			tx_bytes.push_back(frame[i]);
	endtask

	// Mostly well-formed frames with random content; some noise in between,
	// some truncated frames, lengths around the current limit.
	task automatic queue_random_frame();
		int r;
		int len;
		int cut;
		int noise;
		logic [15:0] lim;
		lim = sb.max_payload;
		r   = $urandom_range(0, 99);
		if (r < 10)
			len = 0;
		else if (r < 70)
			len = $urandom_range(1, 8);
		else if (r < 85)
			len = $urandom_range(9, 40);
		else if (r < 92)
			len = (lim < 16'hFFFF) ? int'(lim) + 1 : $urandom_range(9, 40);
		else if (lim <= 16'd64)
			len = int'(lim);
		else if (lim < 16'hFFFF)
			len = $urandom_range(int'(lim) + 1, 65535);
		else
			len = $urandom_range(41, 200);
		if ($urandom_range(0, 99) < 12) begin
			noise = $urandom_range(1, 3);
			repeat (noise)
				tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (len > int'(lim))
			cut = len;                        // dropped: payload never sent
		else if ($urandom_range(0, 99) < 5)
			cut = $urandom_range(1, len + 3); // broken frame
		else
			cut = 0;
		queue_frame(len, $urandom_range(0, 99) < 80, cut);
	endtask

	// Offer one byte and hold it until the transfer happens. s_tvalid is only
	// lowered for a real gap, so it never toggles within one step.
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_rx_byte(b);
	endtask

	task automatic send_queued();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	task automatic run_random(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			queue_random_frame();
			sent += tx_bytes.size();
			send_queued();
		end
	endtask

	// Stop offering, let every expected result drain, then give the two
	// pipeline registers time to clear header bytes that leave no result.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_max_payload(logic [15:0] value);
		logic [31:0] rd;
		apb_write(MAX_PAYLOAD_ADDR, {16'h0000, value});
		apb_read(MAX_PAYLOAD_ADDR, rd);
		sb.set_limit(value);
		sb.check_register({16'h0000, value}, rd);
	endtask

	// Result sink: checks every master-side transfer and throttles m_tready.
	// The long hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata, m_tlast, m_tuser);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] rd;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 3'd0;
		pwdata        = 32'h0;
		steady        = 1'b0;
		long_hold_req = 1'b0;
		sb.restart();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register comes up at its reset value
		apb_read(MAX_PAYLOAD_ADDR, rd);
		sb.check_register({16'h0000, MAX_PAYLOAD_RESET}, rd);

		// Directed: ignored bytes while hunting, empty frames with good and
		// bad sums, a one-byte frame, an oversized header that is dropped and
		// hunting resuming right behind it, then a short bad frame.
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		queue_frame(0, 1'b1, 0);
		queue_frame(0, 1'b0, 0);
		queue_frame(1, 1'b1, 0);
		queue_frame(int'(MAX_PAYLOAD_RESET) + 1, 1'b1, int'(MAX_PAYLOAD_RESET) + 1);
		queue_frame(2, 1'b0, 0);
		send_queued();

		// default limit, with one long receiver hold-off to back up the block
		long_hold_req = 1'b1;
		run_random(500);
		wait_idle();

		// limit zero: only empty frames get through
		set_max_payload(16'h0000);
		run_random(250);
		wait_idle();

		// full-range limit and one frame with a nonzero length high byte,
		// sent flat out
		set_max_payload(16'hFFFF);
		steady = 1'b1;
		queue_frame(300, 1'b1, 0);
		send_queued();
		steady = 1'b0;
		run_random(100);
		wait_idle();

		// small limits so frames sit right at and just above the boundary
		set_max_payload(16'd5);
		run_random(350);
		wait_idle();

		set_max_payload(16'd1);
		run_random(250);
		wait_idle();

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("serial_frame_deframer_unit verification clean");
		end else begin
			$display("serial_frame_deframer_unit verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#40_000_000;
		$display("serial_frame_deframer_unit verification failed");
		$finish;
	end

endmodule

// ===== serial_frame_deframer_unit.f =====
src/sfd_pkg.sv
src/sfd_core.sv
src/serial_frame_deframer_unit.sv
tb/tb_serial_frame_deframer_unit.sv
